/* src/b2bcd_pkg.sv */
// ----------------------------------------------------------------------------
// b2bcd_pkg
// shared constants and types for the binary to packed bcd converter
// ----------------------------------------------------------------------------
package b2bcd_pkg;
    localparam int VALUE_W  = 32;
    localparam int DIGITS   = 10;
    localparam int BCD_W    = DIGITS * 4;
    localparam int STAGES   = 4;
    localparam int SHIFTS_PER_STAGE = VALUE_W / STAGES;

    typedef struct packed {
        logic [VALUE_W-1:0] bin;
        logic [BCD_W-1:0]   bcd;
        logic [3:0]         size;
    } t_dd;

    // one double-dabble step: add 3 to digits >= 5, shift in next bit
    function automatic t_dd dd_step(t_dd x);
        t_dd y;
        logic [BCD_W-1:0] adj;
        adj = x.bcd;
        for (int d = 0; d < DIGITS; d++) begin
            if (adj[d*4 +: 4] >= 4'd5) begin
                adj[d*4 +: 4] = adj[d*4 +: 4] + 4'd3;
            end
        end
        y.bcd  = {adj[BCD_W-2:0], x.bin[VALUE_W-1]};
        y.bin  = {x.bin[VALUE_W-2:0], 1'b0};
        y.size = x.size;
        return y;
    endfunction
endpackage

/* src/b2bcd_conv.sv */
// ----------------------------------------------------------------------------
// b2bcd_conv
// pipelined double dabble, eight shifts per stage, four stages, stallable
// ----------------------------------------------------------------------------
module b2bcd_conv
    import b2bcd_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [VALUE_W-1:0] i_value,
    input  logic [3:0]         i_size,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [BCD_W-1:0]   o_bcd,
    output logic [3:0]         o_size
);
    t_dd  r_st [STAGES];
    logic r_v  [STAGES];
    logic [STAGES-1:0] w_adv;
    t_dd  n_st [STAGES];

    always_comb begin
        t_dd x;
        for (int s = 0; s < STAGES; s++) begin
            if (s == 0) begin
                x.bin = i_value; x.bcd = '0; x.size = i_size;
            end else begin
                x = r_st[s-1];
            end
            for (int k = 0; k < SHIFTS_PER_STAGE; k++) x = dd_step(x);
            n_st[s] = x;
        end
        w_adv[STAGES-1] = !r_v[STAGES-1] || i_ready;
        for (int s = STAGES-2; s >= 0; s--) w_adv[s] = !r_v[s] || w_adv[s+1];
    end

    always_ff @(posedge i_clk) begin
        for (int s = 0; s < STAGES; s++) begin
            if (w_adv[s]) begin
                r_st[s] <= n_st[s];
                if (!i_rst_n) r_v[s] <= 1'b0;
                else r_v[s] <= (s == 0) ? i_valid : r_v[s-1];
            end else if (!i_rst_n) begin
                r_v[s] <= 1'b0;
            end
        end
    end

    assign o_ready = w_adv[0];
    assign o_valid = r_v[STAGES-1];
    assign o_bcd   = r_st[STAGES-1].bcd;
    assign o_size  = r_st[STAGES-1].size;
endmodule

/* src/b2bcd_emit.sv */
// ----------------------------------------------------------------------------
// b2bcd_emit
// counts digits, then sends packed bytes one per cycle while i_ready is high, low byte first
// ----------------------------------------------------------------------------
module b2bcd_emit
    import b2bcd_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [BCD_W-1:0] i_bcd,
    input  logic [3:0]       i_size,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [7:0]       o_data_byte,
    output logic             o_data_valid,
    output logic             o_last,
    output logic             o_status,
    output logic [2:0]       o_byte_count
);
    logic [BCD_W-1:0] r_bcd;
    logic [2:0]       r_nbytes;
    logic [2:0]       r_idx;
    logic             r_fail;
    logic             r_busy;
    logic             r_empty;
    logic [3:0]       w_ndig;
    logic [4:0]       w_need;
    logic [2:0]       w_nb;

    always_comb begin
        w_ndig = 4'd1;
        for (int d = 1; d < DIGITS; d++) begin
            if (i_bcd[d*4 +: 4] != 4'd0) w_ndig = 4'(d + 1);
        end
        w_need = {1'b0, w_ndig} + 5'd1;
        w_nb   = w_need[3:1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (!r_busy || (i_ready && o_last)) begin
            r_busy <= i_valid;
            r_idx  <= '0;
            r_bcd  <= i_bcd;
            if ({1'b0, w_ndig} > {i_size, 1'b0}) begin
                r_fail   <= 1'b1;
                r_nbytes <= (i_size > 4'd5) ? 3'd5 : i_size[2:0];
                r_empty  <= (i_size == 4'd0);
            end else begin
                r_fail   <= 1'b0;
                r_nbytes <= w_nb;
                r_empty  <= 1'b0;
            end
        end else if (i_ready) begin
            r_idx <= r_idx + 3'd1;
            r_bcd <= {8'd0, r_bcd[BCD_W-1:8]};
        end
    end

    assign o_ready      = !r_busy || (i_ready && o_last);
    assign o_valid      = r_busy;
    assign o_data_valid = !r_empty;
    assign o_data_byte  = r_empty ? 8'd0 : r_bcd[7:0];
    assign o_last       = r_empty || (r_idx + 3'd1 == r_nbytes);
    assign o_status     = o_last && r_fail;
    assign o_byte_count = (o_last && !r_fail) ? r_nbytes : 3'd0;
endmodule

/* src/binary_to_packed_bcd_core.sv */
// an accepted item passes the four conversion stage registers and then the sender register
// four double-dabble stages of eight shifts each, then a byte sender
// throughput: one result byte per cycle while i_ready is high, one to five results per item
// the sender output sets the rate; the conversion pipeline takes an item every cycle unless the sender stalls it
// reset: synchronous active low, clears all valid bits, no data lost after
// ----------------------------------------------------------------------------
// binary_to_packed_bcd_core
// 32-bit unsigned to packed bcd, bytes least significant first
// ----------------------------------------------------------------------------
module binary_to_packed_bcd_core
    import b2bcd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_value,
    input  logic [3:0]  i_buffer_bytes,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_data_byte,
    output logic        o_data_valid,
    output logic        o_last,
    output logic        o_status,
    output logic [2:0]  o_byte_count
);
    logic             w_cv;
    logic             w_er;
    logic [BCD_W-1:0] w_bcd;
    logic [3:0]       w_size;

    b2bcd_conv u_conv (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_value(i_value), .i_size(i_buffer_bytes),
        .o_valid(w_cv), .i_ready(w_er), .o_bcd(w_bcd), .o_size(w_size)
    );

    b2bcd_emit u_emit (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(w_cv), .o_ready(w_er), .i_bcd(w_bcd), .i_size(w_size),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_data_byte(o_data_byte), .o_data_valid(o_data_valid),
        .o_last(o_last), .o_status(o_status), .o_byte_count(o_byte_count)
    );
endmodule

/* src/b2bcd_checker.sv */
// ----------------------------------------------------------------------------
// b2bcd_checker
// port level checks of the converter
// ----------------------------------------------------------------------------
module b2bcd_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_ready,
    input logic [7:0] o_data_byte,
    input logic       o_data_valid,
    input logic       o_last,
    input logic       o_status,
    input logic [2:0] o_byte_count
);
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data_byte) && $stable(o_last))
        else $error("output changed under stall");
    a_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last |-> !o_status && o_byte_count == 3'd0 && o_data_valid)
        else $error("bad fields on non last item");
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_data_valid |-> o_last && o_status && o_data_byte == 8'd0)
        else $error("bad empty item");
    a_bcd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_data_byte[3:0] < 4'd10 && o_data_byte[7:4] < 4'd10)
        else $error("non decimal digit");
endmodule

bind binary_to_packed_bcd_core b2bcd_checker u_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_valid(o_valid), .i_ready(i_ready),
    .o_data_byte(o_data_byte), .o_data_valid(o_data_valid), .o_last(o_last),
    .o_status(o_status), .o_byte_count(o_byte_count)
);
